[sv/tlg_pkg.sv]
package tlg_pkg;

  // Field widths
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LEVEL_W = 5;
  localparam int unsigned DWELL_W = 33;
  localparam int unsigned TAU_W   = 31;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FINEST     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAISE_DWELL = 2'd2;

  // Register reset values
  localparam logic [TIME_W-1:0]  RST_MAX_STEP    = 32'd16667;
  localparam logic [LEVEL_W-1:0] RST_FINEST      = 5'd4;
  localparam logic [TAU_W-1:0]   RST_RAISE_DWELL = 31'd500000;

  // Serial divider step counter width
  localparam int unsigned DIV_CNT_W = $clog2(TIME_W + 1);

  typedef struct packed {
    logic [TIME_W-1:0]  max_step_us;
    logic [LEVEL_W-1:0] finest_level;
    logic [TAU_W-1:0]   raise_dwell_us;
  } tlg_cfg_t;

  // Work handed from the front to the back
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]  frame_us;
  } tlg_job_t;

endpackage

[sv/tlg_front.sv]
module tlg_front (
  input  logic                          clk,
  input  logic                          rst,
  input  tlg_pkg::tlg_cfg_t             cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tlg_pkg::TIME_W-1:0]    target_step_us,
  input  logic [tlg_pkg::TIME_W-1:0]    frame_us,
  output logic                          push,
  output tlg_pkg::tlg_job_t             push_job,
  input  logic                          push_ready
);
  import tlg_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE   = 3'b001,
    F_SEARCH = 3'b010,
    F_PUSH   = 3'b100
  } front_state_t;

  front_state_t        state;
  logic [TIME_W-1:0]   target;
  logic [TIME_W-1:0]   frame;
  logic [LEVEL_W-1:0]  k;
  logic [LEVEL_W-1:0]  want;
  logic [LEVEL_W-1:0]  cur_level;
  logic [DWELL_W-1:0]  dwell;

  logic [LEVEL_W-1:0]  cur_level_next;
  logic [DWELL_W-1:0]  dwell_next;
  logic [DWELL_W:0]    sum;
  logic [DWELL_W:0]    cap;
  logic [LEVEL_W-1:0]  down;
  logic                hit;

  assign in_ready = (state == F_IDLE);
  assign push     = (state == F_PUSH) && push_ready;
  assign push_job = '{level: cur_level_next, frame_us: frame};

  // Level k covers the target when target << k reaches the max step
  assign hit = (({{TIME_W{1'b0}}, target} << k) >= {{TIME_W{1'b0}}, cfg.max_step_us});

  // Hysteresis on the kept level and dwell
  always_comb begin
    sum  = (DWELL_W+1)'(dwell) + (DWELL_W+1)'(frame);
    cap  = (DWELL_W+1)'({cfg.raise_dwell_us, 1'b0});
    down = cur_level - LEVEL_W'(1);
    cur_level_next = cur_level;
    dwell_next     = dwell;
    if (want > cur_level) begin
      cur_level_next = cur_level + LEVEL_W'(1);
      dwell_next     = '0;
    end else if (want < cur_level) begin
      if (sum[DWELL_W-1:0] >= DWELL_W'(cfg.raise_dwell_us)) begin
        cur_level_next = (want > down) ? want : down;
        dwell_next     = '0;
      end else begin
        dwell_next = sum[DWELL_W-1:0];
      end
    end else begin
      dwell_next = (sum < cap) ? sum[DWELL_W-1:0] : cap[DWELL_W-1:0];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      cur_level <= '0;
      dwell     <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            if (target_step_us == '0) begin
              state <= F_PUSH;
            end else begin
              state <= F_SEARCH;
            end
          end
        end
        F_SEARCH: begin
          if (k >= cfg.finest_level || hit) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            cur_level <= cur_level_next;
            dwell     <= dwell_next;
            state     <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Payload: capture the item and walk the ladder one level a cycle
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (in_valid) begin
          target <= target_step_us;
          frame  <= frame_us;
          k      <= '0;
          want   <= cfg.finest_level;
        end
      end
      F_SEARCH: begin
        if (k >= cfg.finest_level) begin
          want <= cfg.finest_level;
        end else if (hit) begin
          want <= k;
        end else begin
          k <= k + LEVEL_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/tlg_fifo.sv]
module tlg_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tlg_pkg::tlg_job_t  push_job,
  output logic               push_ready,
  input  logic               pop,
  output tlg_pkg::tlg_job_t  pop_job,
  output logic               pop_valid
);
  import tlg_pkg::*;

  localparam int unsigned DEPTH = 2;

  tlg_job_t     mem [DEPTH];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign push_ready = (count != 2'(DEPTH));
  assign pop_valid  = (count != 2'd0);
  assign pop_job    = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[sv/tlg_div.sv]
module tlg_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tlg_pkg::TIME_W-1:0]  dividend,
  input  logic [tlg_pkg::TIME_W-1:0]  divisor,
  output logic                        busy,
  output logic                        done,
  output logic [tlg_pkg::TIME_W-1:0]  quotient,
  output logic [tlg_pkg::TIME_W-1:0]  remainder
);
  import tlg_pkg::*;

  logic [TIME_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic [TIME_W:0]      shifted;
  logic                 fits;

  // One restoring step: bring down the next dividend bit
  assign shifted = {remainder, quotient[TIME_W-1]};
  assign fits    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(TIME_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs       <= divisor;
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      if (fits) begin
        remainder <= TIME_W'(shifted - {1'b0, dvs});
        quotient  <= {quotient[TIME_W-2:0], 1'b1};
      end else begin
        remainder <= shifted[TIME_W-1:0];
        quotient  <= {quotient[TIME_W-2:0], 1'b0};
      end
    end
  end

endmodule

[sv/tlg_back.sv]
module tlg_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [tlg_pkg::TIME_W-1:0]   max_step_us,
  input  logic                         job_valid,
  input  tlg_pkg::tlg_job_t            job,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tlg_pkg::LEVEL_W-1:0]  level,
  output logic [tlg_pkg::TIME_W-1:0]   substeps,
  output logic [tlg_pkg::TIME_W-1:0]   substep_us
);
  import tlg_pkg::*;

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_LOAD1 = 6'b000010,
    B_WAIT1 = 6'b000100,
    B_LOAD2 = 6'b001000,
    B_WAIT2 = 6'b010000,
    B_DONE  = 6'b100000
  } back_state_t;

  back_state_t         state;
  logic [LEVEL_W-1:0]  lvl;
  logic [TIME_W-1:0]   frame;
  logic [TIME_W-1:0]   n;
  logic [TIME_W-1:0]   quo_last;

  logic [TIME_W-1:0]   step_raw;
  logic [TIME_W-1:0]   step;
  logic [TIME_W-1:0]   n_raw;
  logic                div_start;
  logic [TIME_W-1:0]   div_divisor;
  logic                div_busy;
  logic                div_done;
  logic [TIME_W-1:0]   div_quo;
  logic [TIME_W-1:0]   div_rem;
  logic                load_out;

  assign pop       = (state == B_IDLE) && job_valid;
  assign load_out  = (state == B_DONE) && (!out_valid || out_ready);

  // Ladder step floored to one
  assign step_raw = max_step_us >> lvl;
  assign step     = (step_raw == '0) ? TIME_W'(1) : step_raw;

  // Ceiling of frame / step; floored to one when stored in n
  assign n_raw = div_quo + TIME_W'(div_rem != '0);

  assign div_start   = (state == B_LOAD1) || (state == B_LOAD2);
  assign div_divisor = (state == B_LOAD1) ? step : n;

  tlg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (frame),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Sequence the two divisions
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE:  if (job_valid) state <= B_LOAD1;
        B_LOAD1: state <= B_WAIT1;
        B_WAIT1: if (div_done) state <= B_LOAD2;
        B_LOAD2: state <= B_WAIT2;
        B_WAIT2: if (div_done) state <= B_DONE;
        B_DONE:  if (load_out) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  // Hold the job and intermediate results
  always_ff @(posedge clk) begin
    if (pop) begin
      lvl   <= job.level;
      frame <= job.frame_us;
    end
    if (state == B_WAIT1 && div_done) begin
      n <= (n_raw == '0) ? TIME_W'(1) : n_raw;
    end
    if (state == B_WAIT2 && div_done) begin
      quo_last <= div_quo;
    end
    if (load_out) begin
      level      <= lvl;
      substeps   <= n;
      substep_us <= quo_last;
    end
  end

  a_substeps_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (substeps != '0))
    else $error("substep count is zero");

  a_wait_has_div: assert property (@(posedge clk) disable iff (rst)
    (state == B_WAIT1 || state == B_WAIT2) |-> (div_busy || div_done))
    else $error("waiting on an idle divider");

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

[sv/timestep_ladder_governor_top.sv]
// Front: searches the ladder one level per cycle for the level to use;
//   the back then runs two 32-step serial divisions on the shared divider.
// The back takes a new item only when done with the last; a two-entry
//   queue lets the front take the next item meanwhile.
// Reset (rst, synchronous): level 0, dwell 0, registers to their defaults,
//   queue empty, no result pending.
module timestep_ladder_governor_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tlg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tlg_pkg::TIME_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tlg_pkg::TIME_W-1:0]    target_step_us,
  input  logic [tlg_pkg::TIME_W-1:0]    frame_us,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tlg_pkg::LEVEL_W-1:0]   level,
  output logic [tlg_pkg::TIME_W-1:0]    substeps,
  output logic [tlg_pkg::TIME_W-1:0]    substep_us
);
  import tlg_pkg::*;

  tlg_cfg_t  cfg;
  logic      push;
  tlg_job_t  push_job;
  logic      push_ready;
  logic      pop;
  tlg_job_t  pop_job;
  logic      pop_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_step_us    <= RST_MAX_STEP;
      cfg.finest_level   <= RST_FINEST;
      cfg.raise_dwell_us <= RST_RAISE_DWELL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_STEP:    cfg.max_step_us    <= cfg_data;
        REG_FINEST:      cfg.finest_level   <= cfg_data[LEVEL_W-1:0];
        REG_RAISE_DWELL: cfg.raise_dwell_us <= cfg_data[TAU_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tlg_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .target_step_us (target_step_us),
    .frame_us       (frame_us),
    .push           (push),
    .push_job       (push_job),
    .push_ready     (push_ready)
  );

  tlg_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_job    (pop_job),
    .pop_valid  (pop_valid)
  );

  tlg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .max_step_us (cfg.max_step_us),
    .job_valid   (pop_valid),
    .job         (pop_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .level       (level),
    .substeps    (substeps),
    .substep_us  (substep_us)
  );

endmodule
